// ===== rtl/core/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared constants, types and the restoring-division step used by the
// converter pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // Hue scaling in sixteenths of a degree
  localparam int HUE_SCALE   = 960;   // 60 degrees * 16
  localparam int SECTOR_SPAN = 1920;  // 120 degrees * 16
  localparam int FULL_CIRCLE = 5760;  // 360 degrees * 16

  localparam int CHAN_W  = 8;
  localparam int HUE_W   = 13;
  localparam int SAT_W   = 8;
  localparam int NUM_W   = CHAN_W + HUE_W;  // hue dividend width

  // Division stages and quotient steps per stage
  localparam int DIV_STAGES      = 4;
  localparam int STEPS_PER_STAGE = 4;
  localparam int HUE_STEPS       = HUE_W;
  localparam int SAT_STEPS       = SAT_W;

  // Which channel is largest (red tested first, then green)
  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  // Payload carried through the division stages
  typedef struct packed {
    logic [CHAN_W-1:0] hi;        // brightness and saturation divisor
    logic [CHAN_W-1:0] delta;     // hue divisor
    logic              gray;
    logic [CHAN_W-1:0] hue_rem;
    logic [HUE_W-1:0]  hue_dvd;   // dividend bits still to shift in
    logic [HUE_W-1:0]  hue_q;
    logic [CHAN_W-1:0] sat_rem;
    logic [SAT_W-1:0]  sat_dvd;
    logic [SAT_W-1:0]  sat_q;
  } div_pipe_t;

  // Run one stage worth of restoring-division steps on each divider that still has quotient bits to resolve
  function automatic div_pipe_t div_steps(div_pipe_t p, int base);
    div_pipe_t    q;
    logic [CHAN_W:0] trial;
    q = p;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      if (base + k < HUE_STEPS) begin
        trial     = {q.hue_rem, q.hue_dvd[HUE_W-1]};
        q.hue_dvd = {q.hue_dvd[HUE_W-2:0], 1'b0};
        if (trial >= {1'b0, q.delta}) begin
          q.hue_rem = CHAN_W'(trial - {1'b0, q.delta});
          q.hue_q   = {q.hue_q[HUE_W-2:0], 1'b1};
        end else begin
          q.hue_rem = trial[CHAN_W-1:0];
          q.hue_q   = {q.hue_q[HUE_W-2:0], 1'b0};
        end
      end
      if (base + k < SAT_STEPS) begin
        trial     = {q.sat_rem, q.sat_dvd[SAT_W-1]};
        q.sat_dvd = {q.sat_dvd[SAT_W-2:0], 1'b0};
        if (trial >= {1'b0, q.hi}) begin
          q.sat_rem = CHAN_W'(trial - {1'b0, q.hi});
          q.sat_q   = {q.sat_q[SAT_W-2:0], 1'b1};
        end else begin
          q.sat_rem = trial[CHAN_W-1:0];
          q.sat_q   = {q.sat_q[SAT_W-2:0], 1'b0};
        end
      end
    end
    return q;
  endfunction

endpackage

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Pipelined conversion of 8-bit RGB pixels into hue (1/16 degree),
// saturation and brightness.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the output is not stalled and returns
// one result per pixel, in order. Stage one finds the largest and smallest
// channel and the hue sector, stage two forms the hue and saturation
// dividends, and four division stages each resolve up to four quotient
// bits of two restoring dividers working side by side (13 hue bits, 8
// saturation bits); the last division stage is the output register. Gray
// pixels give hue and saturation zero. A stall only holds the stages that
// are full, so bubbles close up behind it.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HUE_W-1:0]  out_hue,
  output logic [SAT_W-1:0]  out_saturation,
  output logic [CHAN_W-1:0] out_brightness
);

  localparam int NSTAGE = DIV_STAGES + 2;  // stage one, dividend stage, dividers

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] adv;

  // Stage one registers
  logic [CHAN_W-1:0]      s1_hi_r,    s1_hi_nxt;
  logic [CHAN_W-1:0]      s1_delta_r, s1_delta_nxt;
  sector_t                s1_sector_r, s1_sector_nxt;
  logic signed [CHAN_W:0] s1_diff_r,  s1_diff_nxt;

  // Dividend stage and division stages
  div_pipe_t pl_r   [DIV_STAGES+1];
  div_pipe_t pl_nxt [DIV_STAGES+1];

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    adv[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NSTAGE; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage one: largest, smallest, sector and signed channel difference
  always_comb begin
    logic [CHAN_W-1:0] lo;
    s1_hi_nxt = in_red;
    if (in_green > s1_hi_nxt) s1_hi_nxt = in_green;
    if (in_blue > s1_hi_nxt) s1_hi_nxt = in_blue;
    lo = in_red;
    if (in_green < lo) lo = in_green;
    if (in_blue < lo) lo = in_blue;
    s1_delta_nxt = s1_hi_nxt - lo;
    if (s1_hi_nxt == in_red) begin
      s1_sector_nxt = SECTOR_RED;
      s1_diff_nxt   = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (s1_hi_nxt == in_green) begin
      s1_sector_nxt = SECTOR_GREEN;
      s1_diff_nxt   = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      s1_sector_nxt = SECTOR_BLUE;
      s1_diff_nxt   = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s1_hi_r     <= s1_hi_nxt;
      s1_delta_r  <= s1_delta_nxt;
      s1_sector_r <= s1_sector_nxt;
      s1_diff_r   <= s1_diff_nxt;
    end
  end

  // Dividend stage: hue numerator with sector offset, saturation numerator
  always_comb begin
    logic [HUE_W-1:0]         offset;
    logic signed [NUM_W+1:0]  hue_prod;
    logic [NUM_W-1:0]         hue_off;
    logic signed [NUM_W+1:0]  hue_num;
    logic [2*CHAN_W-1:0]      sat_num;
    case (s1_sector_r)
      SECTOR_RED:   offset = s1_diff_r[CHAN_W] ? HUE_W'(FULL_CIRCLE) : '0;
      SECTOR_GREEN: offset = HUE_W'(SECTOR_SPAN);
      SECTOR_BLUE:  offset = HUE_W'(2 * SECTOR_SPAN);
      default:      offset = '0;
    endcase
    hue_prod = (NUM_W+2)'(s1_diff_r) * $signed((NUM_W+2)'(HUE_SCALE));
    hue_off  = NUM_W'(offset) * NUM_W'(s1_delta_r);
    hue_num  = hue_prod + $signed({2'b00, hue_off});
    sat_num  = {s1_delta_r, {CHAN_W{1'b0}}} - (2*CHAN_W)'(s1_delta_r);

    pl_nxt[0].hi      = s1_hi_r;
    pl_nxt[0].delta   = s1_delta_r;
    pl_nxt[0].gray    = (s1_delta_r == '0);
    pl_nxt[0].hue_rem = hue_num[NUM_W-1:HUE_W];
    pl_nxt[0].hue_dvd = hue_num[HUE_W-1:0];
    pl_nxt[0].hue_q   = '0;
    pl_nxt[0].sat_rem = sat_num[2*CHAN_W-1:SAT_W];
    pl_nxt[0].sat_dvd = sat_num[SAT_W-1:0];
    pl_nxt[0].sat_q   = '0;
  end

  // Division stages; the last one zeroes the quotients of gray pixels
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    always_comb begin
      pl_nxt[k+1] = div_steps(pl_r[k], k * STEPS_PER_STAGE);
      if ((k == DIV_STAGES - 1) && pl_nxt[k+1].gray) begin
        pl_nxt[k+1].hue_q = '0;
        pl_nxt[k+1].sat_q = '0;
      end
    end
  end

  // Load each payload register when its stage advances over a full one
  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (adv[k+1] && vld_r[k]) begin
        pl_r[k] <= pl_nxt[k];
      end
    end
  end

  // Drive the result channel from the last division stage
  assign out_valid      = vld_r[NSTAGE-1];
  assign out_hue        = pl_r[DIV_STAGES].hue_q;
  assign out_saturation = pl_r[DIV_STAGES].sat_q;
  assign out_brightness = pl_r[DIV_STAGES].hi;

endmodule
